[rtl/lobm_pkg.sv]
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared widths, codes and record types of the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int ID_W    = 12;
    localparam int PRICE_W = 12;
    localparam int QTY_W   = 16;
    localparam int LINK_W  = ID_W + 1;
    localparam int CNT_W   = 13;
    localparam int VOL_W   = 28;
    localparam int LVL_A_W = PRICE_W + 1;

    localparam logic [PRICE_W-1:0] TOP_TICK = {PRICE_W{1'b1}};
    localparam logic [LINK_W-1:0]  NO_LINK  = {1'b1, {ID_W{1'b0}}};

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_CANCEL = 1'b1;
    localparam logic SIDE_SELL   = 1'b0;
    localparam logic SIDE_BUY    = 1'b1;

    localparam logic [2:0] ST_RESTING   = 3'd0;
    localparam logic [2:0] ST_FILLED    = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_NOT_LIVE  = 3'd3;
    localparam logic [2:0] ST_REJECTED  = 3'd4;

    typedef struct packed {
        logic               live;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [LINK_W-1:0]  prev;
        logic [LINK_W-1:0]  next;
    } t_slot;

    typedef struct packed {
        logic [ID_W-1:0]  head;
        logic [ID_W-1:0]  tail;
        logic [CNT_W-1:0] count;
        logic [VOL_W-1:0] volume;
    } t_level;

    localparam int SLOT_W  = $bits(t_slot);
    localparam int LEVEL_W = $bits(t_level);

endpackage

[rtl/lobm_ram.sv]
// ----------------------------------------------------------------------------
// lobm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lobm_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/limit_order_book_matcher_top.sv]
// ----------------------------------------------------------------------------
// limit_order_book_matcher_top
// Price-time priority order book with matching, run by a small sequencer.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one add or cancel item. Output
// channel: o_valid / i_stall carry one result item per input item.
// An item is taken when valid is high and stall is low.
// After reset the sequencer clears the order and level memories, one entry
// per cycle; o_stall stays high meanwhile.
// Each item is worked through the order RAM and the level RAM, one read and
// one write per RAM per cycle. A rejected item goes straight to the result
// states; an add that rests without trading is also linked behind the tail
// when its level already holds orders; a cancel unlinks the order and, when
// the best level empties, examines price levels for a new best price. Each
// trade also removes every order it empties, with the same rescan.
// One item is in work at a time. The result waits in an output register;
// the next item is taken while it waits, but the following result is held
// until the receiver drops i_stall.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_top
    import lobm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_func,
    input  logic [ID_W-1:0]    i_order_id,
    input  logic               i_side,
    input  logic [PRICE_W-1:0] i_price,
    input  logic [QTY_W-1:0]   i_quantity,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic [QTY_W-1:0]   o_filled_qty,
    output logic [CNT_W-1:0]   o_fill_count,
    output logic [PRICE_W-1:0] o_best_bid_out,
    output logic [PRICE_W-1:0] o_best_ask_out,
    output logic [VOL_W-1:0]   o_best_bid_volume,
    output logic [VOL_W-1:0]   o_best_ask_volume
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_APPEND, S_BEST,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
        S_U0, S_U1, S_U2, S_SCAN, S_SCANW, S_RET,
        S_F0, S_F1, S_F2, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        RET_CANCEL, RET_BID, RET_ASK
    } t_ret;

    t_state             r_state;
    t_ret               r_ret;
    logic [LVL_A_W-1:0] r_clr;
    logic               r_func;
    logic [ID_W-1:0]    r_id;
    logic               r_side;
    logic [PRICE_W-1:0] r_price;
    logic [QTY_W-1:0]   r_qty;
    logic [PRICE_W-1:0] r_bb;
    logic [PRICE_W-1:0] r_ba;
    logic [QTY_W-1:0]   r_filled;
    logic [CNT_W-1:0]   r_fills;
    logic [2:0]         r_status;
    logic               r_self_gone;
    logic [ID_W-1:0]    r_tail;
    t_level             r_blev;
    t_level             r_alev;
    t_slot              r_brec;
    t_slot              r_arec;
    logic [ID_W-1:0]    r_bid_id;
    logic [ID_W-1:0]    r_ask_id;
    logic [QTY_W-1:0]   r_trade;
    logic [ID_W-1:0]    r_u;
    t_slot              r_urec;
    logic [CNT_W-1:0]   r_ucnt;
    logic [VOL_W-1:0]   r_bvol;
    logic [VOL_W-1:0]   r_avol;

    logic               s_we;
    logic [ID_W-1:0]    s_waddr;
    t_slot              s_wdata;
    logic [ID_W-1:0]    s_raddr;
    t_slot              s_rec;
    logic               l_we;
    logic [LVL_A_W-1:0] l_waddr;
    t_level             l_wdata;
    logic [LVL_A_W-1:0] l_raddr;
    t_level             l_rec;

    logic [QTY_W-1:0]   w_trade;
    logic               w_pv_ok;
    logic               w_nx_ok;
    logic               w_cross;

    lobm_ram #(.DATA_W(SLOT_W), .ADDR_W(ID_W)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rec)
    );

    lobm_ram #(.DATA_W(LEVEL_W), .ADDR_W(LVL_A_W)) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rec)
    );

    assign o_stall = (r_state != S_IDLE);
    assign w_trade = (r_brec.qty < s_rec.qty) ? r_brec.qty : s_rec.qty;
    assign w_pv_ok = !r_urec.prev[ID_W];
    assign w_nx_ok = !r_urec.next[ID_W];
    assign w_cross = (r_bb >= r_ba) && (r_bb != '0) &&
                     (r_blev.count != '0) && (l_rec.count != '0);

    // memory port steering
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_id;
        s_wdata = '0;
        s_raddr = r_id;
        l_we    = 1'b0;
        l_waddr = {r_side, r_price};
        l_wdata = '0;
        l_raddr = {r_side, r_price};
        unique case (r_state)
            S_CLEAR: begin
                s_we    = !r_clr[ID_W];
                s_waddr = r_clr[ID_W-1:0];
                l_we    = 1'b1;
                l_waddr = r_clr;
            end
            S_IDLE: begin
                s_raddr = i_order_id;
                l_raddr = {i_side, i_price};
            end
            S_CHECK: begin
                s_raddr = l_rec.tail;
                if (r_func == FUNC_ADD && !s_rec.live && r_qty != '0) begin
                    s_we          = 1'b1;
                    s_wdata.live  = 1'b1;
                    s_wdata.side  = r_side;
                    s_wdata.price = r_price;
                    s_wdata.qty   = r_qty;
                    s_wdata.prev  = (l_rec.count == '0) ? NO_LINK : {1'b0, l_rec.tail};
                    s_wdata.next  = NO_LINK;
                    l_we           = 1'b1;
                    l_wdata.head   = (l_rec.count == '0) ? r_id : l_rec.head;
                    l_wdata.tail   = r_id;
                    l_wdata.count  = l_rec.count + 1'b1;
                    l_wdata.volume = l_rec.volume + VOL_W'(r_qty);
                end
            end
            S_APPEND: begin
                s_we         = 1'b1;
                s_waddr      = r_tail;
                s_wdata      = s_rec;
                s_wdata.next = {1'b0, r_id};
            end
            S_M0: l_raddr = {SIDE_BUY, r_bb};
            S_M1: l_raddr = {SIDE_SELL, r_ba};
            S_M2: s_raddr = r_blev.head;
            S_M3: s_raddr = r_ask_id;
            S_M4: begin
                s_we        = 1'b1;
                s_waddr     = r_bid_id;
                s_wdata     = r_brec;
                s_wdata.qty = r_brec.qty - w_trade;
            end
            S_M5: begin
                s_we           = 1'b1;
                s_waddr        = r_ask_id;
                s_wdata        = r_arec;
                s_wdata.qty    = r_arec.qty - r_trade;
                l_we           = 1'b1;
                l_waddr        = {SIDE_BUY, r_bb};
                l_wdata        = r_blev;
                l_wdata.volume = r_blev.volume - VOL_W'(r_trade);
            end
            S_M6: begin
                l_we           = 1'b1;
                l_waddr        = {SIDE_SELL, r_ba};
                l_wdata        = r_alev;
                l_wdata.volume = r_alev.volume - VOL_W'(r_trade);
            end
            S_U0: begin
                s_raddr      = r_urec.prev[ID_W-1:0];
                l_raddr      = {r_urec.side, r_urec.price};
                s_we         = 1'b1;
                s_waddr      = r_u;
                s_wdata      = r_urec;
                s_wdata.live = 1'b0;
            end
            S_U1: begin
                s_raddr      = r_urec.next[ID_W-1:0];
                s_we         = w_pv_ok;
                s_waddr      = r_urec.prev[ID_W-1:0];
                s_wdata      = s_rec;
                s_wdata.next = r_urec.next;
                l_we           = 1'b1;
                l_waddr        = {r_urec.side, r_urec.price};
                l_wdata.head   = w_pv_ok ? l_rec.head : r_urec.next[ID_W-1:0];
                l_wdata.tail   = w_nx_ok ? l_rec.tail : r_urec.prev[ID_W-1:0];
                l_wdata.count  = l_rec.count - 1'b1;
                l_wdata.volume = l_rec.volume - VOL_W'(r_urec.qty);
            end
            S_U2: begin
                s_we         = w_nx_ok;
                s_waddr      = r_urec.next[ID_W-1:0];
                s_wdata      = s_rec;
                s_wdata.prev = r_urec.prev;
            end
            S_SCAN: l_raddr = r_urec.side ? {SIDE_BUY, r_bb} : {SIDE_SELL, r_ba};
            S_F0:   l_raddr = {SIDE_BUY, r_bb};
            S_F1:   l_raddr = {SIDE_SELL, r_ba};
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_bb    <= '0;
            r_ba    <= TOP_TICK;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == {LVL_A_W{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_func      <= i_func;
                        r_id        <= i_order_id;
                        r_side      <= i_side;
                        r_price     <= i_price;
                        r_qty       <= i_quantity;
                        r_filled    <= '0;
                        r_fills     <= '0;
                        r_self_gone <= 1'b0;
                        r_state     <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_func == FUNC_CANCEL) begin
                        if (s_rec.live) begin
                            r_u     <= r_id;
                            r_urec  <= s_rec;
                            r_ret   <= RET_CANCEL;
                            r_state <= S_U0;
                        end else begin
                            r_status <= ST_NOT_LIVE;
                            r_state  <= S_F0;
                        end
                    end else if (s_rec.live || r_qty == '0) begin
                        r_status <= ST_REJECTED;
                        r_state  <= S_F0;
                    end else begin
                        r_status <= ST_RESTING;
                        r_tail   <= l_rec.tail;
                        r_state  <= (l_rec.count == '0) ? S_BEST : S_APPEND;
                    end
                end
                S_APPEND: r_state <= S_BEST;
                S_BEST: begin
                    if (r_side == SIDE_BUY && r_price > r_bb) begin
                        r_bb <= r_price;
                    end
                    if (r_side == SIDE_SELL && r_price < r_ba) begin
                        r_ba <= r_price;
                    end
                    r_state <= S_M0;
                end
                S_M0: r_state <= S_M1;
                S_M1: begin
                    r_blev  <= l_rec;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_alev   <= l_rec;
                    r_bid_id <= r_blev.head;
                    r_ask_id <= l_rec.head;
                    r_state  <= w_cross ? S_M3 : S_F0;
                end
                S_M3: begin
                    r_brec  <= s_rec;
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_trade    <= w_trade;
                    r_brec.qty <= r_brec.qty - w_trade;
                    r_arec     <= s_rec;
                    r_filled   <= r_filled + w_trade;
                    r_state    <= S_M5;
                end
                S_M5: begin
                    r_arec.qty <= r_arec.qty - r_trade;
                    r_state    <= S_M6;
                end
                S_M6: begin
                    r_fills <= r_fills + 1'b1;
                    r_state <= S_U0;
                    if (r_brec.qty == '0) begin
                        r_u    <= r_bid_id;
                        r_urec <= r_brec;
                        r_ret  <= RET_BID;
                    end else begin
                        r_u    <= r_ask_id;
                        r_urec <= r_arec;
                        r_ret  <= RET_ASK;
                    end
                end
                S_U0: begin
                    if (r_u == r_id && r_func == FUNC_ADD) begin
                        r_self_gone <= 1'b1;
                    end
                    r_state <= S_U1;
                end
                S_U1: begin
                    r_ucnt  <= l_rec.count - 1'b1;
                    r_state <= S_U2;
                end
                S_U2: begin
                    // rescan only when the emptied level held the best price
                    if (r_ucnt == '0 &&
                        ((r_urec.side && r_urec.price == r_bb) ||
                         (!r_urec.side && r_urec.price == r_ba))) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_RET;
                    end
                end
                S_SCAN: begin
                    if (r_urec.side ? (r_bb == '0) : (r_ba == TOP_TICK)) begin
                        r_state <= S_RET;
                    end else begin
                        r_state <= S_SCANW;
                    end
                end
                S_SCANW: begin
                    if (l_rec.count == '0) begin
                        if (r_urec.side) begin
                            r_bb <= r_bb - 1'b1;
                        end else begin
                            r_ba <= r_ba + 1'b1;
                        end
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_RET;
                    end
                end
                S_RET: begin
                    unique case (r_ret)
                        RET_CANCEL: begin
                            r_status <= ST_CANCELLED;
                            r_state  <= S_F0;
                        end
                        RET_BID: begin
                            if (r_arec.qty == '0) begin
                                r_fills <= r_fills + 1'b1;
                                r_u     <= r_ask_id;
                                r_urec  <= r_arec;
                                r_ret   <= RET_ASK;
                                r_state <= S_U0;
                            end else begin
                                r_state <= S_M0;
                            end
                        end
                        RET_ASK: r_state <= S_M0;
                        default: r_state <= S_M0;
                    endcase
                end
                S_F0: r_state <= S_F1;
                S_F1: begin
                    r_bvol  <= l_rec.volume;
                    r_state <= S_F2;
                end
                S_F2: begin
                    r_avol <= l_rec.volume;
                    if (r_self_gone) begin
                        r_status <= ST_FILLED;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold the result until the output register is free
                    if (!o_valid || !i_stall) begin
                        o_valid           <= 1'b1;
                        o_status          <= r_status;
                        o_filled_qty      <= r_filled;
                        o_fill_count      <= r_fills;
                        o_best_bid_out    <= r_bb;
                        o_best_ask_out    <= r_ba;
                        o_best_bid_volume <= r_bvol;
                        o_best_ask_volume <= r_avol;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!s_we && !l_we))
        else $error("memory write while idle");

    a_no_fill_on_cancel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_CANCELLED || o_status == ST_NOT_LIVE ||
                     o_status == ST_REJECTED))
        |-> (o_filled_qty == '0 && o_fill_count == '0))
        else $error("fill reported for cancel or reject");

    a_filled_has_qty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FILLED) |-> (o_fill_count != '0))
        else $error("filled add without fills");

    a_trade_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M5) |-> (r_trade != '0))
        else $error("zero-size trade");

    a_loaded_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!o_valid || !i_stall)) |=> (o_valid && r_state == S_IDLE))
        else $error("result not loaded");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks the order book matcher against a predictor of the book that the
// testbench keeps itself: directed rejects, crosses, sweeps and extremes,
// a long receiver hold-off, then random order flow around a narrow price band.
// ----------------------------------------------------------------------------
module tb;
    import lobm_pkg::*;

    localparam int NSLOT       = 4096;
    localparam int NLVL        = 4096;
    localparam int NONE        = 4096;
    localparam int WDOG_LIMIT  = 60000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [2:0]         status;
        logic [QTY_W-1:0]   filled;
        logic [CNT_W-1:0]   fills;
        logic [PRICE_W-1:0] bid;
        logic [PRICE_W-1:0] ask;
        logic [VOL_W-1:0]   bid_vol;
        logic [VOL_W-1:0]   ask_vol;
    } t_book_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_func;
    logic [ID_W-1:0]    i_order_id;
    logic               i_side;
    logic [PRICE_W-1:0] i_price;
    logic [QTY_W-1:0]   i_quantity;
    logic               o_valid;
    logic               i_stall;
    logic [2:0]         o_status;
    logic [QTY_W-1:0]   o_filled_qty;
    logic [CNT_W-1:0]   o_fill_count;
    logic [PRICE_W-1:0] o_best_bid_out;
    logic [PRICE_W-1:0] o_best_ask_out;
    logic [VOL_W-1:0]   o_best_bid_volume;
    logic [VOL_W-1:0]   o_best_ask_volume;

    limit_order_book_matcher_top u_top (.*);

    // book shadow; level arrays are indexed [side][price], side 1 is buy
    bit  ord_live [NSLOT];
    bit  ord_side [NSLOT];
    int  ord_price[NSLOT];
    int  ord_qty  [NSLOT];
    int  ord_prev [NSLOT];
    int  ord_next [NSLOT];
    int  lvl_head [2][NLVL];
    int  lvl_tail [2][NLVL];
    int  lvl_cnt  [2][NLVL];
    int  lvl_vol  [2][NLVL];
    int  top_bid;
    int  top_ask;

    t_book_result pending_results[$];
    int  errors;
    bit  hold_req;
    bit  quiet;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void unlink_order(int s);
        int b, p, pv, nx;
        b  = int'(ord_side[s]);
        p  = ord_price[s];
        pv = ord_prev[s];
        nx = ord_next[s];
        if (pv != NONE) ord_next[pv] = nx; else lvl_head[b][p] = nx;
        if (nx != NONE) ord_prev[nx] = pv; else lvl_tail[b][p] = pv;
        lvl_vol[b][p] = lvl_vol[b][p] - ord_qty[s];
        lvl_cnt[b][p] = lvl_cnt[b][p] - 1;
        ord_live[s] = 1'b0;
        if (lvl_cnt[b][p] == 0) begin
            if (b == 1 && p == top_bid) begin
                while (top_bid > 0 && lvl_cnt[1][top_bid] == 0) top_bid--;
            end else if (b == 0 && p == top_ask) begin
                while (top_ask < NLVL - 1 && lvl_cnt[0][top_ask] == 0) top_ask++;
            end
        end
    endfunction

    function automatic t_book_result apply_item(logic f, int id, int sd, int p, int q);
        t_book_result r;
        int filled, fills, bo, ao, t;
        filled = 0;
        fills  = 0;
        if (f == FUNC_CANCEL) begin
            if (ord_live[id]) begin
                unlink_order(id);
                r.status = ST_CANCELLED;
            end else begin
                r.status = ST_NOT_LIVE;
            end
        end else if (ord_live[id] || q == 0) begin
            r.status = ST_REJECTED;
        end else begin
            ord_live[id]  = 1'b1;
            ord_side[id]  = sd[0];
            ord_price[id] = p;
            ord_qty[id]   = q;
            ord_next[id]  = NONE;
            if (lvl_cnt[sd][p] == 0) begin
                ord_prev[id] = NONE;
                lvl_head[sd][p] = id;
            end else begin
                ord_prev[id] = lvl_tail[sd][p];
                ord_next[lvl_tail[sd][p]] = id;
            end
            lvl_tail[sd][p] = id;
            lvl_vol[sd][p] += q;
            lvl_cnt[sd][p] += 1;
            if (sd == 1 && p > top_bid) top_bid = p;
            if (sd == 0 && p < top_ask) top_ask = p;
            // trade heads while the book crosses
            while (top_bid >= top_ask && top_bid > 0 &&
                   lvl_cnt[1][top_bid] != 0 && lvl_cnt[0][top_ask] != 0) begin
                bo = lvl_head[1][top_bid];
                ao = lvl_head[0][top_ask];
                t = (ord_qty[bo] < ord_qty[ao]) ? ord_qty[bo] : ord_qty[ao];
                ord_qty[bo] -= t;
                ord_qty[ao] -= t;
                lvl_vol[1][top_bid] -= t;
                lvl_vol[0][top_ask] -= t;
                filled += t;
                if (ord_qty[bo] == 0) begin unlink_order(bo); fills++; end
                if (ord_qty[ao] == 0) begin unlink_order(ao); fills++; end
            end
            r.status = ord_live[id] ? ST_RESTING : ST_FILLED;
        end
        r.filled  = filled[QTY_W-1:0];
        r.fills   = fills[CNT_W-1:0];
        r.bid     = top_bid[PRICE_W-1:0];
        r.ask     = top_ask[PRICE_W-1:0];
        r.bid_vol = lvl_vol[1][top_bid][VOL_W-1:0];
        r.ask_vol = lvl_vol[0][top_ask][VOL_W-1:0];
        return r;
    endfunction

    // drive one item at the falling edge, hold it until taken
    task automatic send_item(logic f, int id, int sd, int p, int q);
        if (!quiet && $urandom_range(3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= f;
        i_order_id <= id[ID_W-1:0];
        i_side     <= sd[0];
        i_price    <= p[PRICE_W-1:0];
        i_quantity <= q[QTY_W-1:0];
        do @(posedge i_clk); while (o_stall);
        pending_results.insert(pending_results.size(), apply_item(f, id, sd, p, q));
        @(negedge i_clk);
    endtask

    task automatic place_order(int id, int sd, int p, int q);
        send_item(FUNC_ADD, id, sd, p, q);
    endtask

    task automatic pull_order(int id);
        send_item(FUNC_CANCEL, id, $urandom_range(1), $urandom_range(4095),
                  $urandom_range(65535));
    endtask

    // result checker
    initial begin
        t_book_result e;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with no item pending: status %0d", o_status);
                    errors++;
                end else begin
                    e = pending_results.pop_front();
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status); errors++;
                    end
                    if (o_filled_qty !== e.filled) begin
                        $error("filled_qty exp %0d got %0d", e.filled, o_filled_qty);
                        errors++;
                    end
                    if (o_fill_count !== e.fills) begin
                        $error("fill_count exp %0d got %0d", e.fills, o_fill_count);
                        errors++;
                    end
                    if (o_best_bid_out !== e.bid) begin
                        $error("best_bid_out exp %0d got %0d", e.bid, o_best_bid_out);
                        errors++;
                    end
                    if (o_best_ask_out !== e.ask) begin
                        $error("best_ask_out exp %0d got %0d", e.ask, o_best_ask_out);
                        errors++;
                    end
                    if (o_best_bid_volume !== e.bid_vol) begin
                        $error("best_bid_volume exp %0d got %0d", e.bid_vol,
                               o_best_bid_volume);
                        errors++;
                    end
                    if (o_best_ask_volume !== e.ask_vol) begin
                        $error("best_ask_volume exp %0d got %0d", e.ask_vol,
                               o_best_ask_volume);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver stalls: random bursts, or one long hold on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic test_rejects();
        place_order(5, SIDE_SELL, 2050, 10);
        place_order(5, SIDE_BUY, 2000, 7);      // live id
        place_order(6, SIDE_BUY, 2000, 0);      // zero size
        pull_order(6);                          // never added
        pull_order(5);
        pull_order(5);                          // already gone
    endtask

    task automatic test_cross();
        place_order(6, SIDE_SELL, 2050, 10);
        place_order(7, SIDE_SELL, 2050, 5);
        place_order(8, SIDE_SELL, 2052, 20);
        place_order(9, SIDE_BUY, 2052, 25);     // sweeps two levels, last ask partial
        place_order(10, SIDE_BUY, 2060, 10);    // fills fully
        place_order(11, SIDE_BUY, 2040, 3);
        pull_order(11);                         // bid level empties
    endtask

    task automatic test_extremes();
        place_order(4095, SIDE_SELL, 4095, 65535);
        place_order(0, SIDE_BUY, 0, 1);         // bid at zero never trades
        place_order(12, SIDE_SELL, 0, 4);
        place_order(1, SIDE_BUY, 4095, 65535);  // crosses both
        pull_order(12);                         // already filled
        pull_order(0);
        place_order(2730, SIDE_BUY, 1365, 21845);
        pull_order(2730);
    endtask

    task automatic test_pressure();
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++) place_order(100 + k, k % 2, 2045 + k, 5 + k);
        for (int k = 0; k < 12; k++) pull_order(100 + k);
    endtask

    task automatic test_random(int n);
        int id, p, q;
        for (int k = 0; k < n; k++) begin
            if (k > n - 100) quiet = 1'b1;
            id = ($urandom_range(6) == 0) ? $urandom_range(4095) : 200 + $urandom_range(47);
            if ($urandom_range(3) == 0) begin
                pull_order(id);
            end else begin
                p = ($urandom_range(19) == 0) ? $urandom_range(4095)
                                              : 2040 + $urandom_range(15);
                q = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(1, 200);
                place_order(id, $urandom_range(1), p, q);
            end
        end
    endtask

    initial begin
        errors     = 0;
        hold_req   = 1'b0;
        quiet      = 1'b0;
        top_bid    = 0;
        top_ask    = NLVL - 1;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_func     = FUNC_ADD;
        i_order_id = '0;
        i_side     = SIDE_SELL;
        i_price    = '0;
        i_quantity = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_rejects();
        test_cross();
        test_extremes();
        test_pressure();
        test_random(500);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
